### design/lzwvd_pkg.sv
// ----------------------------------------------------------------------------
// lzwvd_pkg
// Shared constants, command and status types for the variable width LZW
// decoder.
// ----------------------------------------------------------------------------
package lzwvd_pkg;

   localparam int TableDepth  = 8192;
   localparam int MaxString   = 512;
   localparam int StartWidth  = 9;
   localparam int MaxWidth    = 13;
   localparam int ClearCode   = 256;
   localparam int CounterWrap = 8190;

   localparam int TableSize  = (TableDepth < 8192) ? TableDepth : 8192;
   localparam int CutLen     = (MaxString < 512) ? MaxString : 512;
   localparam int TabAw      = $clog2(TableSize);
   localparam int StackAw    = $clog2(CutLen);
   localparam int StackDepth = 1 << StackAw;
   localparam int CodeW      = MaxWidth;
   localparam int LenW       = TabAw + 1;
   localparam int CntW       = $clog2(CutLen + 1);
   localparam int EntryW     = 1 + CodeW + 8;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_KNOWN,
      KIND_UNKNOWN
   } walk_kind_type;

   typedef struct packed {
      logic          accept;
      logic          restart_table;
      logic          wr_first;
      logic          start_walk;
      walk_kind_type kind;
      logic          wr_unknown;
      logic          step_leaf;
      logic          rd_walk;
      logic          step_entry;
      logic          rd_prefix;
      logic          finish;
      logic          emit_rd;
      logic          emit_put;
   } cmd_type;

   typedef struct packed {
      logic code_ready;
      logic is_clear;
      logic is_known;
      logic table_full;
      logic walk_leaf;
      logic ent_link;
      logic ent_prefix_leaf;
      logic last_byte;
      logic word_full;
      logic eos;
   } status_type;

endpackage

### design/lzwvd_req_if.sv
// ----------------------------------------------------------------------------
// lzwvd_req_if
// Request channel: one packed byte of the code stream per request.
// ----------------------------------------------------------------------------
interface lzwvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

### design/lzwvd_rsp_if.sv
// ----------------------------------------------------------------------------
// lzwvd_rsp_if
// Response channel: one word of up to eight decoded bytes per response.
// ----------------------------------------------------------------------------
interface lzwvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic        end_of_string;
   logic        overflow;

   modport source (output valid, output out_bytes, output byte_count,
                   output end_of_string, output overflow, input ready);
   modport sink   (input valid, input out_bytes, input byte_count,
                   input end_of_string, input overflow, output ready);
endinterface

### design/lzwvd_datapath.sv
// ----------------------------------------------------------------------------
// lzwvd_datapath
// Bit unpacking, width schedule, code table, string stack and word packing.
// ----------------------------------------------------------------------------
module lzwvd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lzwvd_pkg::cmd_type    cmd,
   output lzwvd_pkg::status_type st,
   input  logic [7:0]            in_byte,
   output logic [63:0]           out_bytes,
   output logic [3:0]            byte_count,
   output logic                  end_of_string,
   output logic                  overflow
);

   logic [19:0] bit_buffer_ff;
   logic [4:0]  bits_held_ff;
   logic [3:0]  code_width_ff;
   logic [13:0] code_counter_ff;
   logic [lzwvd_pkg::LenW-1:0]  next_entry_ff;
   logic [lzwvd_pkg::CodeW-1:0] prev_code_ff;
   logic [7:0]                  prev_first_ff;

   logic [lzwvd_pkg::CodeW-1:0] code_ff;
   logic [lzwvd_pkg::CodeW-1:0] walk_ff;
   lzwvd_pkg::walk_kind_type    kind_ff;
   logic [lzwvd_pkg::LenW-1:0]  len_ff;
   logic [7:0]                  first_ff;
   logic [lzwvd_pkg::CntW-1:0]  n_ff;
   logic [lzwvd_pkg::CntW-1:0]  pos_ff;
   logic                        ovf_ff;
   logic [2:0]                  k_ff;
   logic [63:0]                 word_ff;
   logic [63:0]                 rsp_bytes_ff;
   logic [3:0]                  rsp_cnt_ff;
   logic                        rsp_eos_ff;
   logic                        rsp_ovf_ff;

   logic [lzwvd_pkg::EntryW-1:0] code_table [lzwvd_pkg::TableSize];
   logic [lzwvd_pkg::EntryW-1:0] tbl_q_ff;
   logic [7:0]                   string_stack [lzwvd_pkg::StackDepth];
   logic [7:0]                   stack_q_ff;

   logic [19:0] buf_sh;
   logic [19:0] buf_keep;
   logic [19:0] shifted;
   logic [4:0]  held_sum;
   logic [4:0]  held_n;
   logic [13:0] cnt_s;
   logic [3:0]  w_s;
   logic [3:0]  w_g;
   logic [14:0] lim;
   logic [13:0] mask;
   logic [lzwvd_pkg::CodeW-1:0] code_x;

   logic                         tbl_we;
   logic [lzwvd_pkg::TabAw-1:0]  tbl_wa;
   logic [lzwvd_pkg::EntryW-1:0] tbl_wd;
   logic                         tbl_re;
   logic [lzwvd_pkg::TabAw-1:0]  tbl_ra;
   logic [lzwvd_pkg::CodeW-1:0]  prefix;
   logic                         push;
   logic [7:0]                   push_byte;
   logic [lzwvd_pkg::CodeW-1:0]  walk_start;
   logic [lzwvd_pkg::LenW-1:0]   diff;
   logic [63:0]                  word_put;
   logic                         table_full;

   always_comb begin
      buf_sh   = {bit_buffer_ff[11:0], in_byte};
      held_sum = bits_held_ff + 5'd8;
      if (32'(code_counter_ff) > lzwvd_pkg::CounterWrap) begin
         cnt_s = 14'(lzwvd_pkg::ClearCode);
         w_s   = 4'(lzwvd_pkg::StartWidth);
      end else begin
         cnt_s = code_counter_ff;
         w_s   = code_width_ff;
      end
      lim = (15'd1 << w_s) - 15'd1;
      w_g = ({1'b0, cnt_s} > lim) ? w_s + 4'd1 : w_s;
      held_n   = held_sum - {1'b0, w_g};
      shifted  = buf_sh >> held_n;
      mask     = (14'd1 << w_g) - 14'd1;
      code_x   = shifted[lzwvd_pkg::CodeW-1:0] & mask[lzwvd_pkg::CodeW-1:0];
      buf_keep = buf_sh & ((20'd1 << held_n) - 20'd1);
   end

   assign table_full = 32'(next_entry_ff) >= lzwvd_pkg::TableSize;
   assign prefix     = tbl_q_ff[lzwvd_pkg::EntryW-2:8];

   always_comb begin
      st                 = '0;
      st.code_ready      = held_sum >= {1'b0, w_g};
      st.is_clear        = 32'(code_ff) == lzwvd_pkg::ClearCode;
      st.is_known        = 32'(code_ff) < lzwvd_pkg::ClearCode ||
                           (32'(code_ff) > lzwvd_pkg::ClearCode &&
                            32'(code_ff) < 32'(next_entry_ff));
      st.table_full      = table_full;
      st.walk_leaf       = 32'(walk_ff) < lzwvd_pkg::ClearCode ||
                           32'(walk_ff) >= lzwvd_pkg::TableSize;
      st.ent_link        = tbl_q_ff[lzwvd_pkg::EntryW-1];
      st.ent_prefix_leaf = 32'(prefix) < lzwvd_pkg::ClearCode ||
                           32'(prefix) >= lzwvd_pkg::TableSize;
      st.last_byte       = (pos_ff + 1'b1) == n_ff;
      st.word_full       = k_ff == 3'd7;
      st.eos             = rsp_eos_ff;
   end

   always_comb begin
      tbl_we = 1'b0;
      tbl_wa = next_entry_ff[lzwvd_pkg::TabAw-1:0];
      tbl_wd = {1'b1, prev_code_ff, prev_first_ff};
      if (cmd.wr_first) begin
         tbl_we = 1'b1;
         tbl_wa = lzwvd_pkg::TabAw'(lzwvd_pkg::ClearCode);
         tbl_wd = {1'b0, {lzwvd_pkg::CodeW{1'b0}}, code_ff[7:0]};
      end else if (cmd.wr_unknown) begin
         tbl_we = 1'b1;
      end else if (cmd.finish && kind_ff == lzwvd_pkg::KIND_KNOWN && !table_full) begin
         tbl_we = 1'b1;
         tbl_wd = {1'b1, prev_code_ff, first_ff};
      end
      tbl_re = cmd.rd_walk | cmd.rd_prefix;
      tbl_ra = cmd.rd_prefix ? prefix[lzwvd_pkg::TabAw-1:0] : walk_ff[lzwvd_pkg::TabAw-1:0];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         code_table[tbl_wa] <= tbl_wd;
      end
      if (tbl_re) begin
         tbl_q_ff <= code_table[tbl_ra];
      end
   end

   assign push      = cmd.step_leaf | cmd.step_entry;
   assign push_byte = cmd.step_entry ? tbl_q_ff[7:0] : walk_ff[7:0];
   assign diff      = len_ff - lzwvd_pkg::LenW'(1) - lzwvd_pkg::LenW'(pos_ff);

   always_ff @(posedge clock) begin
      if (push) begin
         string_stack[len_ff[lzwvd_pkg::StackAw-1:0]] <= push_byte;
      end
      if (cmd.emit_rd) begin
         stack_q_ff <= string_stack[diff[lzwvd_pkg::StackAw-1:0]];
      end
   end

   always_comb begin
      case (cmd.kind)
         lzwvd_pkg::KIND_KNOWN:   walk_start = code_ff;
         lzwvd_pkg::KIND_UNKNOWN: walk_start = next_entry_ff[lzwvd_pkg::CodeW-1:0];
         default:                 walk_start = {{(lzwvd_pkg::CodeW-8){1'b0}}, code_ff[7:0]};
      endcase
      word_put = word_ff;
      word_put[8*(7-k_ff) +: 8] = stack_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff   <= '0;
         bits_held_ff    <= '0;
         code_width_ff   <= 4'(lzwvd_pkg::StartWidth);
         code_counter_ff <= 14'(lzwvd_pkg::ClearCode);
         next_entry_ff   <= lzwvd_pkg::LenW'(lzwvd_pkg::ClearCode + 1);
         prev_code_ff    <= '0;
         prev_first_ff   <= '0;
      end else begin
         if (cmd.accept) begin
            code_width_ff <= w_g;
            if (st.code_ready) begin
               bit_buffer_ff   <= buf_keep;
               bits_held_ff    <= held_n;
               code_counter_ff <= cnt_s + 14'd1;
            end else begin
               bit_buffer_ff   <= buf_sh;
               bits_held_ff    <= held_sum;
               code_counter_ff <= cnt_s;
            end
         end
         if (cmd.restart_table) begin
            next_entry_ff <= lzwvd_pkg::LenW'(lzwvd_pkg::ClearCode);
         end
         if (cmd.wr_first) begin
            next_entry_ff <= lzwvd_pkg::LenW'(lzwvd_pkg::ClearCode + 1);
         end
         if (cmd.finish) begin
            prev_first_ff <= first_ff;
            case (kind_ff)
               lzwvd_pkg::KIND_KNOWN: begin
                  prev_code_ff <= code_ff;
                  if (!table_full) begin
                     next_entry_ff <= next_entry_ff + 1'b1;
                  end
               end
               lzwvd_pkg::KIND_UNKNOWN: begin
                  prev_code_ff  <= next_entry_ff[lzwvd_pkg::CodeW-1:0];
                  next_entry_ff <= next_entry_ff + 1'b1;
               end
               default: begin
                  prev_code_ff <= {{(lzwvd_pkg::CodeW-8){1'b0}}, first_ff};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         code_ff <= code_x;
      end
      if (cmd.start_walk) begin
         walk_ff <= walk_start;
         kind_ff <= cmd.kind;
         len_ff  <= '0;
      end
      if (push) begin
         len_ff   <= len_ff + 1'b1;
         first_ff <= push_byte;
      end
      if (cmd.step_entry) begin
         walk_ff <= prefix;
      end
      if (cmd.finish) begin
         if (32'(len_ff) > lzwvd_pkg::CutLen) begin
            n_ff   <= lzwvd_pkg::CntW'(lzwvd_pkg::CutLen);
            ovf_ff <= 1'b1;
         end else begin
            n_ff   <= lzwvd_pkg::CntW'(len_ff);
            ovf_ff <= 1'b0;
         end
         pos_ff  <= '0;
         k_ff    <= '0;
         word_ff <= '0;
      end
      if (cmd.emit_put) begin
         pos_ff <= pos_ff + 1'b1;
         if (st.last_byte || st.word_full) begin
            rsp_bytes_ff <= word_put;
            rsp_cnt_ff   <= {1'b0, k_ff} + 4'd1;
            rsp_eos_ff   <= st.last_byte;
            rsp_ovf_ff   <= ovf_ff;
            word_ff      <= '0;
            k_ff         <= '0;
         end else begin
            word_ff <= word_put;
            k_ff    <= k_ff + 3'd1;
         end
      end
   end

   assign out_bytes     = rsp_bytes_ff;
   assign byte_count    = rsp_cnt_ff;
   assign end_of_string = rsp_eos_ff;
   assign overflow      = rsp_ovf_ff;

endmodule

### design/lzwvd_controller.sv
// ----------------------------------------------------------------------------
// lzwvd_controller
// Sequences unpacking, dictionary update, chain walk and word output.
// ----------------------------------------------------------------------------
module lzwvd_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lzwvd_pkg::status_type st,
   output lzwvd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK_ISSUE,
      ST_WALK_DATA,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_PUT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_CLEARED,
      PH_NORMAL
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_comb begin
      cmd      = '0;
      cmd.kind = lzwvd_pkg::KIND_SINGLE;
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (st.code_ready) begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            state_in = ST_WALK_ISSUE;
            if (st.is_clear) begin
               cmd.restart_table = 1'b1;
               phase_in          = PH_CLEARED;
               state_in          = ST_IDLE;
            end else begin
               cmd.start_walk = 1'b1;
               phase_in       = PH_NORMAL;
               case (phase_ff)
                  PH_CLEARED: cmd.wr_first = 1'b1;
                  PH_NORMAL: begin
                     if (st.is_known) begin
                        cmd.kind = lzwvd_pkg::KIND_KNOWN;
                     end else if (!st.table_full) begin
                        cmd.kind       = lzwvd_pkg::KIND_UNKNOWN;
                        cmd.wr_unknown = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK_ISSUE: begin
            if (st.walk_leaf) begin
               cmd.step_leaf = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.rd_walk = 1'b1;
               state_in    = ST_WALK_DATA;
            end
         end
         ST_WALK_DATA: begin
            cmd.step_entry = 1'b1;
            if (!st.ent_link) begin
               state_in = ST_FINISH;
            end else if (st.ent_prefix_leaf) begin
               state_in = ST_WALK_ISSUE;
            end else begin
               cmd.rd_prefix = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            cmd.emit_put = 1'b1;
            state_in     = (st.last_byte || st.word_full) ? ST_OUT : ST_EMIT_RD;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = st.eos ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

endmodule

### design/lzw_variable_width_decoder_core.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_core
// LZW decoder for 9 to 13 bit codes packed most significant bit first.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_chan  in         in_byte
//  rsp_chan  out        out_bytes, byte_count, end_of_string, overflow
//
//  A clear code restarts the code table and emits no word. Any other code
//  is expanded by a chain walk through the code table, and the string is
//  emitted byte by byte through the string stack port and packed into
//  words, subject to any stall on rsp_chan.
//  One request is in flight at a time; reset is synchronous and needs no
//  clearing pass.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_core (
   input  logic          clock,
   input  logic          reset,
   lzwvd_req_if.sink     req_chan,
   lzwvd_rsp_if.source   rsp_chan
);

   lzwvd_pkg::cmd_type    cmd;
   lzwvd_pkg::status_type st;

   lzwvd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   lzwvd_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .in_byte       (req_chan.in_byte),
      .out_bytes     (rsp_chan.out_bytes),
      .byte_count    (rsp_chan.byte_count),
      .end_of_string (rsp_chan.end_of_string),
      .overflow      (rsp_chan.overflow)
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.byte_count >= 4'd1 && rsp_chan.byte_count <= 4'd8))
      else $error("byte count out of range");

   a_full_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.end_of_string) |-> rsp_chan.byte_count == 4'd8)
      else $error("short word before end of string");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a word is pending");
`endif

endmodule

### test/lzw_variable_width_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_core_tb
// Feeds packed code streams into the LZW decoder core and checks every
// decoded word against a cycle-free model of the decoder kept in the bench.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_core_tb;

   localparam int CyclesLimit = 1500000;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic        end_of_string;
      logic        overflow;
   } word_type;

   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_CLEARED,
      PHASE_NORMAL
   } phase_type;

   logic clock;
   logic reset;
   lzwvd_req_if req_chan ();
   lzwvd_rsp_if rsp_chan ();

   lzw_variable_width_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // decoder model state
   logic [21:0] dict [lzwvd_pkg::TableSize];
   logic [7:0]  str_buf [lzwvd_pkg::CutLen];
   logic [19:0] bit_store;
   int unsigned held_bits;
   int unsigned width;
   int unsigned code_cnt;
   int unsigned next_code;
   int unsigned prev_code;
   logic [7:0]  prev_first;
   phase_type   phase;

   word_type    expected_words [$];
   int unsigned mismatches;
   int unsigned cycle_count;
   bit          idle_enable;
   bit          hold_off;
   int unsigned emitted_codes;

   // stream packer
   logic [31:0] pack_acc;
   int unsigned pack_bits;
   int unsigned stream_width;
   int unsigned stream_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CyclesLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int unsigned walk_len(input int unsigned code,
                                            output logic [7:0] first);
      int unsigned len;
      int unsigned c;
      int unsigned pos;
      logic [21:0] e;
      logic [7:0]  b;
      len = 0;
      c = code;
      b = '0;
      for (int n = 0; n <= lzwvd_pkg::TableSize; n++) begin
         len++;
         if (c < 256 || c >= lzwvd_pkg::TableSize) begin
            b = c[7:0];
            break;
         end
         e = dict[c];
         b = e[7:0];
         if (!e[21]) break;
         c = e[20:8];
      end
      first = b;
      pos = len;
      c = code;
      for (int n = 0; n < len; n++) begin
         pos--;
         if (c < 256 || c >= lzwvd_pkg::TableSize) begin
            b = c[7:0];
            e = '0;
         end else begin
            e = dict[c];
            b = e[7:0];
         end
         if (pos < lzwvd_pkg::CutLen) str_buf[pos] = b;
         if (!e[21]) break;
         c = e[20:8];
      end
      return len;
   endfunction

   task automatic queue_words(input int unsigned len);
      int unsigned n;
      int unsigned i;
      int unsigned cnt;
      word_type    w;
      n = (len > lzwvd_pkg::CutLen) ? lzwvd_pkg::CutLen : len;
      i = 0;
      emitted_codes++;
      while (i < n) begin
         w = '0;
         cnt = (n - i > 8) ? 8 : n - i;
         for (int k = 0; k < cnt; k++) w.out_bytes[56 - 8 * k +: 8] = str_buf[i + k];
         i += cnt;
         w.byte_count    = cnt[3:0];
         w.end_of_string = (i >= n);
         w.overflow      = (len > lzwvd_pkg::CutLen);
         expected_words.insert(expected_words.size(), w);
      end
   endtask

   task automatic queue_single(input logic [7:0] b);
      str_buf[0] = b;
      prev_code  = b;
      prev_first = b;
      queue_words(1);
   endtask

   task automatic decode_code(input int unsigned v);
      int unsigned len;
      logic [7:0]  first;
      if (phase == PHASE_FIRST) begin
         if (v == lzwvd_pkg::ClearCode) begin
            next_code = 256;
            phase = PHASE_CLEARED;
         end else begin
            phase = PHASE_NORMAL;
            queue_single(v[7:0]);
         end
      end else if (phase == PHASE_CLEARED) begin
         if (v == lzwvd_pkg::ClearCode) begin
            next_code = 256;
         end else begin
            dict[256] = {14'd0, v[7:0]};
            next_code = 257;
            phase = PHASE_NORMAL;
            queue_single(v[7:0]);
         end
      end else if (v == lzwvd_pkg::ClearCode) begin
         next_code = 256;
         phase = PHASE_CLEARED;
      end else if (v < 256 || (v > 256 && v < next_code)) begin
         len = walk_len(v, first);
         if (next_code < lzwvd_pkg::TableSize) begin
            dict[next_code] = {1'b1, prev_code[12:0], first};
            next_code++;
         end
         prev_code  = v;
         prev_first = first;
         queue_words(len);
      end else if (next_code >= lzwvd_pkg::TableSize) begin
         queue_single(v[7:0]);
      end else begin
         dict[next_code] = {1'b1, prev_code[12:0], prev_first};
         len = walk_len(next_code, first);
         prev_code = next_code;
         next_code++;
         queue_words(len);
      end
   endtask

   task automatic predict_byte(input logic [7:0] in_byte);
      int unsigned code;
      bit_store = {bit_store[11:0], in_byte};
      held_bits += 8;
      if (code_cnt > lzwvd_pkg::CounterWrap) begin
         width = lzwvd_pkg::StartWidth;
         code_cnt = 256;
      end
      if (code_cnt > (1 << width) - 1) width++;
      if (held_bits < width) return;
      held_bits -= width;
      code = (bit_store >> held_bits) & ((1 << width) - 1);
      bit_store &= (20'd1 << held_bits) - 1;
      code_cnt++;
      decode_code(code);
   endtask

   task automatic model_reset();
      for (int i = 0; i < lzwvd_pkg::TableSize; i++) dict[i] = '0;
      bit_store  = '0;
      held_bits  = 0;
      width      = lzwvd_pkg::StartWidth;
      code_cnt   = 256;
      next_code  = 257;
      prev_code  = 0;
      prev_first = '0;
      phase      = PHASE_FIRST;
   endtask

   task automatic send_byte(input logic [7:0] b);
      while (idle_enable && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_byte(b);
      @(negedge clock);
   endtask

   // pack codes at the width schedule the decoder will follow
   task automatic send_code(input int unsigned code);
      if (stream_cnt > lzwvd_pkg::CounterWrap) begin
         stream_width = lzwvd_pkg::StartWidth;
         stream_cnt = 256;
      end
      if (stream_cnt > (1 << stream_width) - 1) stream_width++;
      pack_acc  = (pack_acc << stream_width) | (code & ((1 << stream_width) - 1));
      pack_bits += stream_width;
      stream_cnt++;
      while (pack_bits >= 8) begin
         pack_bits -= 8;
         send_byte(8'((pack_acc >> pack_bits) & 8'hff));
      end
   endtask

   // valid codes from the packer's view of the table
   function automatic int unsigned pick_code(input int unsigned table_next);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return lzwvd_pkg::ClearCode;
      if (r < 40 || table_next <= 257) return $urandom_range(255);
      if (r < 45) return table_next;
      return $urandom_range(table_next - 1, 257);
   endfunction

   always @(posedge clock) begin
      word_type got;
      word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.out_bytes, rsp_chan.byte_count,
                rsp_chan.end_of_string, rsp_chan.overflow};
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", got.out_bytes);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            if (got.out_bytes !== want.out_bytes) begin
               $error("out_bytes expected %h actual %h", want.out_bytes, got.out_bytes);
               mismatches++;
            end
            if (got.byte_count !== want.byte_count) begin
               $error("byte_count expected %0d actual %0d", want.byte_count,
                      got.byte_count);
               mismatches++;
            end
            if (got.end_of_string !== want.end_of_string) begin
               $error("end_of_string expected %b actual %b", want.end_of_string,
                      got.end_of_string);
               mismatches++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow expected %b actual %b", want.overflow, got.overflow);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !hold_off && !(idle_enable && $urandom_range(99) < 25);
   end

   // track the next table entry the way the decoder will
   int unsigned pk_next;
   bit          pk_started;

   task automatic send_tracked(input int unsigned code);
      if (code == lzwvd_pkg::ClearCode) begin
         pk_next = 256;
         pk_started = 1'b0;
      end else if (!pk_started) begin
         pk_started = 1'b1;
         pk_next = (pk_next == 256) ? 257 : pk_next;
      end else if (pk_next < lzwvd_pkg::TableSize) begin
         pk_next++;
      end
      send_code(code);
   endtask

   task automatic test_directed();
      send_tracked(65);
      send_tracked(66);
      send_tracked(257);
      send_tracked(259);
      send_tracked(260);
      send_tracked(0);
      send_tracked(255);
      send_tracked(lzwvd_pkg::ClearCode);
      send_tracked(lzwvd_pkg::ClearCode);
      send_tracked(511);
      send_tracked(256 + 1);
      send_tracked(258);
      send_tracked(lzwvd_pkg::ClearCode);
      send_tracked(300);
   endtask

   task automatic test_random_bytes();
      repeat (40) send_byte(8'($urandom_range(255)));
   endtask

   task automatic test_long_strings();
      // grow one chain by a byte per code
      send_tracked(lzwvd_pkg::ClearCode);
      send_tracked(7);
      for (int i = 0; i < 36; i++) send_tracked(pk_next);
   endtask

   task automatic test_random_streams();
      while (emitted_codes < 250) send_tracked(pick_code(pk_next));
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (20) send_tracked(pick_code(pk_next));
      join
   endtask

   task automatic test_width_wrap();
      // take the code counter past the first width step with cheap clears
      idle_enable = 1'b0;
      while (stream_cnt < 560) begin
         send_tracked($urandom_range(99) < 90 ? lzwvd_pkg::ClearCode : $urandom_range(255));
      end
      repeat (30) send_tracked(pick_code(pk_next));
      idle_enable = 1'b1;
   endtask

   initial begin
      mismatches     = 0;
      emitted_codes  = 0;
      idle_enable    = 1'b0;
      hold_off       = 1'b0;
      pack_acc       = '0;
      pack_bits      = 0;
      stream_width   = lzwvd_pkg::StartWidth;
      stream_cnt     = 256;
      pk_next        = 257;
      pk_started     = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      reset = 1'b1;
      model_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_strings();
      idle_enable = 1'b1;
      test_random_streams();
      test_backpressure();
      test_width_wrap();
      test_random_bytes();
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
